### rtl/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and state codes for the button debouncer with long press.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned StateW = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [StateW-1:0] ST_RELEASED   = 3'd0;
  localparam logic [StateW-1:0] ST_REL_EDGE   = 3'd1;
  localparam logic [StateW-1:0] ST_PRESS_EDGE = 3'd2;
  localparam logic [StateW-1:0] ST_HELD       = 3'd3;
  localparam logic [StateW-1:0] ST_LONG_EVT   = 3'd4;
  localparam logic [StateW-1:0] ST_LONG_HELD  = 3'd5;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_DELAY   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS_DELAY = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_INTERVAL  = 2'd2;

  localparam logic [TimeW-1:0] DEBOUNCE_DELAY_RST   = 32'd10;
  localparam logic [TimeW-1:0] LONG_PRESS_DELAY_RST = 32'd1000;
  localparam logic [TimeW-1:0] REPEAT_INTERVAL_RST  = 32'd200;

  typedef struct packed {
    logic             raw_level;
    logic [TimeW-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [StateW-1:0] button_state;
    logic              press_event;
    logic              release_event;
    logic              long_press_event;
    logic              is_down;
    logic              is_long_down;
  } out_item_t;

endpackage

### rtl/bdlp_sampler.sv
// ----------------------------------------------------------------------------
// bdlp_sampler
// Time-gated shift history of the raw level; flags a fully set history.
// ----------------------------------------------------------------------------
module bdlp_sampler import bdlp_pkg::*; #(
  parameter int unsigned HISTORY_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             raw_level_i,
  input  logic [TimeW-1:0] now_ms_i,
  input  logic [TimeW-1:0] debounce_delay_i,
  output logic             full_o
);

  logic [HISTORY_BITS-1:0] history_q, history_d;
  logic [TimeW-1:0]        last_q;
  logic [TimeW-1:0]        elapsed;
  logic                    take;

  assign elapsed = now_ms_i - last_q;
  assign take    = elapsed > debounce_delay_i;

  always_comb begin
    history_d = history_q;
    if (take) begin
      history_d = {raw_level_i, history_q[HISTORY_BITS-1:1]};
    end
  end

  assign full_o = &history_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      history_q <= '0;
      last_q    <= '0;
    end else if (en_i && take) begin
      history_q <= history_d;
      last_q    <= now_ms_i;
    end
  end

endmodule

### rtl/bdlp_fsm.sv
// ----------------------------------------------------------------------------
// bdlp_fsm
// Press, hold, long-press and repeat state machine with result decode.
// ----------------------------------------------------------------------------
module bdlp_fsm import bdlp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             full_i,
  input  logic [TimeW-1:0] now_ms_i,
  input  logic [TimeW-1:0] long_press_delay_i,
  input  logic [TimeW-1:0] repeat_interval_i,
  output out_item_t        result_o
);

  logic [StateW-1:0] state_q, state_d;
  logic [TimeW-1:0]  press_start_q, press_start_d;
  logic [TimeW-1:0]  repeat_start_q, repeat_start_d;
  logic [TimeW-1:0]  press_age, repeat_age;

  assign press_age  = now_ms_i - press_start_q;
  assign repeat_age = now_ms_i - repeat_start_q;

  always_comb begin
    state_d        = state_q;
    press_start_d  = press_start_q;
    repeat_start_d = repeat_start_q;
    if (full_i) begin
      case (state_q)
        ST_PRESS_EDGE: state_d = ST_HELD;
        ST_HELD: begin
          if (press_age > long_press_delay_i) begin
            state_d        = ST_LONG_EVT;
            repeat_start_d = now_ms_i;
          end
        end
        ST_LONG_EVT: state_d = ST_LONG_HELD;
        ST_LONG_HELD: begin
          if (repeat_age > repeat_interval_i) begin
            state_d        = ST_LONG_EVT;
            repeat_start_d = now_ms_i;
          end
        end
        default: begin
          state_d       = ST_PRESS_EDGE;
          press_start_d = now_ms_i;
        end
      endcase
    end else if (state_q inside {[ST_PRESS_EDGE:ST_LONG_HELD]}) begin
      state_d       = ST_REL_EDGE;
      press_start_d = now_ms_i;
    end else begin
      state_d = ST_RELEASED;
    end
  end

  always_comb begin
    result_o.button_state     = state_d;
    result_o.press_event      = (state_d == ST_PRESS_EDGE);
    result_o.release_event    = (state_d == ST_REL_EDGE);
    result_o.long_press_event = (state_d == ST_LONG_EVT);
    result_o.is_down          = (state_d == ST_PRESS_EDGE) || (state_d == ST_HELD);
    result_o.is_long_down     = (state_d == ST_LONG_EVT) || (state_d == ST_LONG_HELD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_RELEASED;
      press_start_q  <= '0;
      repeat_start_q <= '0;
    end else if (en_i) begin
      state_q        <= state_d;
      press_start_q  <= press_start_d;
      repeat_start_q <= repeat_start_d;
    end
  end

endmodule

### rtl/button_debounce_long_press_fsm.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press_fsm
// One poll per cycle sustained unless out_ready_i stalls the result register.
// One input register, one compare/shift/state update, one result register.
// Reset clears history, times and state; registers return to 10/1000/200 ms.
// ----------------------------------------------------------------------------
module button_debounce_long_press_fsm import bdlp_pkg::*; #(
  parameter int unsigned HISTORY_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TimeW-1:0]   cfg_wdata_i
);

  logic             in_valid_q;
  in_item_t         in_q;
  logic             out_valid_q;
  out_item_t        out_q;
  out_item_t        result;
  logic             advance;
  logic             full;
  logic [TimeW-1:0] debounce_delay_q;
  logic [TimeW-1:0] long_press_delay_q;
  logic [TimeW-1:0] repeat_interval_q;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_delay_q   <= DEBOUNCE_DELAY_RST;
      long_press_delay_q <= LONG_PRESS_DELAY_RST;
      repeat_interval_q  <= REPEAT_INTERVAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE_DELAY:   debounce_delay_q   <= cfg_wdata_i;
        CFG_LONG_PRESS_DELAY: long_press_delay_q <= cfg_wdata_i;
        CFG_REPEAT_INTERVAL:  repeat_interval_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  bdlp_sampler #(
    .HISTORY_BITS(HISTORY_BITS)
  ) u_sampler (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .raw_level_i     (in_q.raw_level),
    .now_ms_i        (in_q.now_ms),
    .debounce_delay_i(debounce_delay_q),
    .full_o          (full)
  );

  bdlp_fsm u_fsm (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (advance),
    .full_i            (full),
    .now_ms_i          (in_q.now_ms),
    .long_press_delay_i(long_press_delay_q),
    .repeat_interval_i (repeat_interval_q),
    .result_o          (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
